### sv/ndllo_pkg.sv
// Package for the ND link-layer option checker: parse phases, verdict codes,
// ICMPv6/option constants and the result word layout. No dependencies.
package ndllo_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    // byte position saturates at MAX_FRAME_BYTES, so it must hold that value
    localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
    // option pointer may run one full option (255 * 8) past the last parsed byte
    localparam int NEXT_W = $clog2(MAX_FRAME_BYTES + 2048);

    localparam int L2_LEN_W = 5;
    localparam int MAC_W    = 48;
    localparam int BYTE_W   = 8;

    localparam logic [L2_LEN_W-1:0] L2_LEN_RESET = L2_LEN_W'(14);

    localparam logic [POS_W-1:0] SRC_MAC_FIRST = POS_W'(6);
    localparam logic [POS_W-1:0] SRC_MAC_END   = POS_W'(12);

    localparam logic [NEXT_W-1:0] IPV6_HDR_BYTES = NEXT_W'(40);

    localparam logic [BYTE_W-1:0] ICMP_ROUTER_SOLICIT   = 8'd133;
    localparam logic [BYTE_W-1:0] ICMP_ROUTER_ADVERT    = 8'd134;
    localparam logic [BYTE_W-1:0] ICMP_NEIGHBOR_SOLICIT = 8'd135;
    localparam logic [BYTE_W-1:0] ICMP_NEIGHBOR_ADVERT  = 8'd136;

    // fixed message body length before the options, counted from the type byte
    localparam logic [NEXT_W-1:0] BODY_RS = NEXT_W'(8);
    localparam logic [NEXT_W-1:0] BODY_RA = NEXT_W'(16);
    localparam logic [NEXT_W-1:0] BODY_NS = NEXT_W'(24);
    localparam logic [NEXT_W-1:0] BODY_NA = NEXT_W'(24);

    localparam logic [1:0] OPT_NONE       = 2'd0;
    localparam logic [1:0] OPT_SOURCE_LLA = 2'd1;
    localparam logic [1:0] OPT_TARGET_LLA = 2'd2;

    localparam logic [2:0] MAC_LAST_TAKEN = 3'd5;

    typedef enum logic [1:0] {
        VERDICT_UNCHECKED = 2'd0,
        VERDICT_NO_OPTION = 2'd1,
        VERDICT_MATCH     = 2'd2,
        VERDICT_MISMATCH  = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_SKIP      = 3'd1,
        PH_LEN_MATCH = 3'd2,
        PH_LEN_OTHER = 3'd3,
        PH_MAC       = 3'd4,
        PH_DONE      = 3'd5
    } phase_t;

    // first field in the highest bits
    typedef struct packed {
        logic [MAC_W-1:0] announced_mac;
        logic [MAC_W-1:0] source_mac;
        verdict_t         verdict;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

### sv/nd_link_layer_option_check.sv
// Top level of the IPv6 ND link-layer address option checker.
// Depends on ndllo_pkg for constants, phase enum and result word layout.
//
// Takes one frame byte per word on s_axis (tlast marks the final byte) and
// gives one result word per frame on m_axis. The frame state (position,
// source MAC, option pointer, option MAC) is updated in the cycle the byte
// is accepted, so s_axis can run at one byte per cycle, with no gaps while
// the skid is empty. On the last byte the verdict is written to a two-deep
// output buffer (output register plus skid); s_axis_tready drops only while
// both are full. Position counts saturate at MAX_FRAME_BYTES; bytes past it
// are not parsed. l2_header_len is written through cfg_* and must only
// change between frames.
module nd_link_layer_option_check
    import ndllo_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: l2_header_len
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [L2_LEN_W-1:0]    cfg_data,
    // input bytes
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] packet_byte
    input  logic                   s_axis_tlast,   // last_byte
    // results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [1:0] verdict, [49:2] source_mac,
                                                   // [97:50] announced_mac, rest zero
);

    // configuration
    logic [L2_LEN_W-1:0] l2_len_reg;

    // frame state
    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic [MAC_W-1:0]  src_mac_reg,  src_mac_next;
    logic [1:0]        wanted_reg,   wanted_next;
    phase_t            phase_reg,    phase_next;
    logic [NEXT_W-1:0] opt_at_reg,   opt_at_next;
    logic [MAC_W-1:0]  opt_mac_reg,  opt_mac_next;
    logic [2:0]        taken_reg,    taken_next;
    verdict_t          outcome_reg,  outcome_next;

    // output buffer
    logic    out_valid_reg,  out_valid_next;
    result_t out_data_reg,   out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;

    logic              in_acc;
    logic              push;
    logic              pop;
    logic              parse_en;
    logic [BYTE_W-1:0] b;
    logic [NEXT_W-1:0] pos_ext;
    logic [NEXT_W-1:0] icmp_at;
    result_t           result;

    // updated values before the end-of-frame clear
    logic [1:0]        wanted_upd;
    phase_t            phase_upd;
    logic [NEXT_W-1:0] opt_at_upd;
    logic [MAC_W-1:0]  opt_mac_upd;
    logic [2:0]        taken_upd;
    verdict_t          outcome_upd;
    logic [MAC_W-1:0]  src_mac_upd;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign push          = in_acc && s_axis_tlast;
    assign pop           = out_valid_reg && m_axis_tready;

    assign b        = s_axis_tdata;
    assign parse_en = (pos_reg != POS_W'(MAX_FRAME_BYTES));
    assign pos_ext  = NEXT_W'(pos_reg);
    assign icmp_at  = NEXT_W'(l2_len_reg) + IPV6_HDR_BYTES;

    // source MAC: frame bytes 6..11, first byte ends up most significant
    always_comb
    begin
        src_mac_upd = src_mac_reg;
        if (parse_en && pos_reg >= SRC_MAC_FIRST && pos_reg < SRC_MAC_END)
        begin
            src_mac_upd = {src_mac_reg[MAC_W-9:0], b};
        end
    end

    // parse phase: next-state logic
    always_comb
    begin
        phase_upd = phase_reg;
        if (parse_en)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_ext == icmp_at)
                    begin
                        if (b inside {ICMP_ROUTER_SOLICIT, ICMP_ROUTER_ADVERT,
                                      ICMP_NEIGHBOR_SOLICIT, ICMP_NEIGHBOR_ADVERT})
                        begin
                            phase_upd = PH_SKIP;
                        end
                        else
                        begin
                            phase_upd = PH_DONE;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (pos_ext == opt_at_reg)
                    begin
                        if (b == '0)
                        begin
                            phase_upd = PH_DONE;
                        end
                        else if (b == BYTE_W'(wanted_reg))
                        begin
                            phase_upd = PH_LEN_MATCH;
                        end
                        else
                        begin
                            phase_upd = PH_LEN_OTHER;
                        end
                    end
                end
                PH_LEN_MATCH:
                begin
                    phase_upd = (b == '0) ? PH_DONE : PH_MAC;
                end
                PH_LEN_OTHER:
                begin
                    phase_upd = (b == '0) ? PH_DONE : PH_SKIP;
                end
                PH_MAC:
                begin
                    if (taken_reg == MAC_LAST_TAKEN)
                    begin
                        phase_upd = PH_DONE;
                    end
                end
                default:
                begin
                    phase_upd = phase_reg;
                end
            endcase
        end
    end

    // parse datapath: option pointer, wanted option, option MAC, outcome
    always_comb
    begin
        wanted_upd  = wanted_reg;
        opt_at_upd  = opt_at_reg;
        opt_mac_upd = opt_mac_reg;
        taken_upd   = taken_reg;
        outcome_upd = outcome_reg;
        if (parse_en)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_ext == icmp_at)
                    begin
                        case (b)
                            ICMP_ROUTER_SOLICIT:
                            begin
                                wanted_upd = OPT_SOURCE_LLA;
                                opt_at_upd = icmp_at + BODY_RS;
                            end
                            ICMP_ROUTER_ADVERT:
                            begin
                                wanted_upd = OPT_SOURCE_LLA;
                                opt_at_upd = icmp_at + BODY_RA;
                            end
                            ICMP_NEIGHBOR_SOLICIT:
                            begin
                                wanted_upd = OPT_SOURCE_LLA;
                                opt_at_upd = icmp_at + BODY_NS;
                            end
                            ICMP_NEIGHBOR_ADVERT:
                            begin
                                wanted_upd = OPT_TARGET_LLA;
                                opt_at_upd = icmp_at + BODY_NA;
                            end
                            default:
                            begin
                                wanted_upd  = OPT_NONE;
                                outcome_upd = VERDICT_UNCHECKED;
                            end
                        endcase
                    end
                end
                PH_SKIP:
                begin
                    // option type zero ends the search
                    if (pos_ext == opt_at_reg && b == '0)
                    begin
                        outcome_upd = VERDICT_NO_OPTION;
                    end
                end
                PH_LEN_MATCH:
                begin
                    if (b == '0)
                    begin
                        outcome_upd = VERDICT_NO_OPTION;
                    end
                    else
                    begin
                        opt_mac_upd = '0;
                        taken_upd   = '0;
                    end
                end
                PH_LEN_OTHER:
                begin
                    // zero length would loop forever: stop instead
                    if (b == '0)
                    begin
                        outcome_upd = VERDICT_NO_OPTION;
                    end
                    else
                    begin
                        opt_at_upd = opt_at_reg + NEXT_W'({b, 3'b000});
                    end
                end
                PH_MAC:
                begin
                    opt_mac_upd = {opt_mac_reg[MAC_W-9:0], b};
                    taken_upd   = taken_reg + 3'd1;
                    if (taken_reg == MAC_LAST_TAKEN)
                    begin
                        outcome_upd = ({opt_mac_reg[MAC_W-9:0], b} == src_mac_reg)
                                      ? VERDICT_MATCH : VERDICT_MISMATCH;
                    end
                end
                default:
                begin
                    outcome_upd = outcome_reg;
                end
            endcase
        end
    end

    // verdict from the state after this byte; truncated option -> no option
    always_comb
    begin
        result.source_mac    = src_mac_upd;
        result.announced_mac = '0;
        case (phase_upd)
            PH_DONE:   result.verdict = outcome_upd;
            PH_HEADER: result.verdict = VERDICT_UNCHECKED;
            default:   result.verdict = VERDICT_NO_OPTION;
        endcase
        if (result.verdict == VERDICT_MATCH || result.verdict == VERDICT_MISMATCH)
        begin
            result.announced_mac = opt_mac_upd;
        end
    end

    // frame state: hold when idle, advance on a byte, clear after the last byte
    always_comb
    begin
        pos_next     = pos_reg;
        src_mac_next = src_mac_reg;
        wanted_next  = wanted_reg;
        phase_next   = phase_reg;
        opt_at_next  = opt_at_reg;
        opt_mac_next = opt_mac_reg;
        taken_next   = taken_reg;
        outcome_next = outcome_reg;
        if (in_acc)
        begin
            if (s_axis_tlast)
            begin
                pos_next     = '0;
                src_mac_next = '0;
                wanted_next  = OPT_NONE;
                phase_next   = PH_HEADER;
                opt_at_next  = '0;
                opt_mac_next = '0;
                taken_next   = '0;
                outcome_next = VERDICT_UNCHECKED;
            end
            else
            begin
                pos_next     = parse_en ? pos_reg + POS_W'(1) : pos_reg;
                src_mac_next = src_mac_upd;
                wanted_next  = wanted_upd;
                phase_next   = phase_upd;
                opt_at_next  = opt_at_upd;
                opt_mac_next = opt_mac_upd;
                taken_next   = taken_upd;
                outcome_next = outcome_upd;
            end
        end
    end

    // two-deep output buffer; skid only fills while the output register is held
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next = result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l2_len_reg     <= L2_LEN_RESET;
            pos_reg        <= '0;
            src_mac_reg    <= '0;
            wanted_reg     <= OPT_NONE;
            phase_reg      <= PH_HEADER;
            opt_at_reg     <= '0;
            opt_mac_reg    <= '0;
            taken_reg      <= '0;
            outcome_reg    <= VERDICT_UNCHECKED;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                l2_len_reg <= cfg_data;
            end
            pos_reg        <= pos_next;
            src_mac_reg    <= src_mac_next;
            wanted_reg     <= wanted_next;
            phase_reg      <= phase_next;
            opt_at_reg     <= opt_at_next;
            opt_mac_reg    <= opt_mac_next;
            taken_reg      <= taken_next;
            outcome_reg    <= outcome_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), out_data_reg};

endmodule
